// ===== rtl/core/bci_pkg.sv =====
// Shared widths, command codes and controller/datapath interface types for the curve interpolator.
package bci_pkg;

	// Field widths
	localparam int CHG_W  = 17;
	localparam int VOLT_W = 17;
	localparam int RES_W  = 20;
	localparam int CNT_W  = 7;
	localparam int PIDX_W = 6;

	// Default table depth
	localparam int MAX_POINTS_DEF = 64;

	// Divider: quotient magnitude always stays below 2^QUOT_W
	localparam int QUOT_W = 20;
	localparam int QCNT_W = $clog2(QUOT_W);
	// Product magnitude width: |dy| < 2^RES_W, numerator < 2^CHG_W
	localparam int MAG_W  = RES_W + CHG_W;

	// Saturation limits
	localparam logic [VOLT_W-1:0] VOLT_MAX = '1;
	localparam logic [RES_W-1:0]  RES_MAX  = '1;

	// Request types
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Read address select
	localparam logic [1:0] SEL_ZERO   = 2'd0;
	localparam logic [1:0] SEL_LAST   = 2'd1;
	localparam logic [1:0] SEL_SEARCH = 2'd2;
	localparam logic [1:0] SEL_NEXT   = 2'd3;

	// Result source select
	localparam logic [1:0] EMIT_EMPTY  = 2'd0;
	localparam logic [1:0] EMIT_RD     = 2'd1;
	localparam logic [1:0] EMIT_LEFT   = 2'd2;
	localparam logic [1:0] EMIT_INTERP = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic       wr;
		logic       load;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       srch_upd;
		logic       latch_a;
		logic       latch_b;
		logic       mul;
		logic       abs_init;
		logic       div_step;
		logic       emit;
		logic [1:0] emit_sel;
	} bci_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic n_zero;
		logic c_le_rd;
		logic c_ge_rd;
		logic srch_done;
		logic den_zero;
		logic div_last;
	} bci_sts_t;

endpackage

// ===== rtl/core/bci_ctrl.sv =====
// Sequencing state machine: table write, end checks, binary search, interpolation, divide.
module bci_ctrl import bci_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     req_type,
	input  bci_sts_t sts,
	output bci_cmd_t cmd,
	output logic     busy
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK0 = 4'd1;
	localparam logic [3:0] S_CHKL = 4'd2;
	localparam logic [3:0] S_SRCH = 4'd3;
	localparam logic [3:0] S_RDA  = 4'd4;
	localparam logic [3:0] S_RDB  = 4'd5;
	localparam logic [3:0] S_MUL  = 4'd6;
	localparam logic [3:0] S_ABS  = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req_type == REQ_WRITE) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.load   = 1'b1;
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = SEL_ZERO;
						state_nxt  = S_CHK0;
					end
				end
			end
			S_CHK0: begin
				// entry 0 on the read port
				if (sts.n_zero) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EMIT_EMPTY;
					state_nxt    = S_IDLE;
				end else if (sts.c_le_rd) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EMIT_RD;
					state_nxt    = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = SEL_LAST;
					state_nxt  = S_CHKL;
				end
			end
			S_CHKL: begin
				// last entry on the read port
				if (sts.c_ge_rd) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EMIT_RD;
					state_nxt    = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = SEL_SEARCH;
					state_nxt  = sts.srch_done ? S_RDA : S_SRCH;
				end
			end
			S_SRCH: begin
				cmd.srch_upd = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = SEL_SEARCH;
				state_nxt    = sts.srch_done ? S_RDA : S_SRCH;
			end
			S_RDA: begin
				cmd.latch_a = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = SEL_NEXT;
				state_nxt   = S_RDB;
			end
			S_RDB: begin
				cmd.latch_b = 1'b1;
				state_nxt   = S_MUL;
			end
			S_MUL: begin
				// repeated or descending charges: take the left point
				if (sts.den_zero) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EMIT_LEFT;
					state_nxt    = S_IDLE;
				end else begin
					cmd.mul   = 1'b1;
					state_nxt = S_ABS;
				end
			end
			S_ABS: begin
				cmd.abs_init = 1'b1;
				state_nxt    = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				cmd.emit     = 1'b1;
				cmd.emit_sel = EMIT_INTERP;
				state_nxt    = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/bci_dp.sv =====
// Datapath: curve memory, search bounds, multiply, serial divide and result register.
module bci_dp import bci_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bci_cmd_t          cmd,
	output bci_sts_t          sts,
	input  logic [CNT_W-1:0]  point_count,
	input  logic [PIDX_W-1:0] point_index,
	input  logic [CHG_W-1:0]  point_charge,
	input  logic [VOLT_W-1:0] point_voltage,
	input  logic [RES_W-1:0]  point_resistance,
	input  logic [CHG_W-1:0]  query_charge,
	output logic [VOLT_W-1:0] voltage,
	output logic [RES_W-1:0]  resistance,
	output logic              out_of_model,
	output logic              result_valid
);

	localparam int IW    = $clog2(MAX_POINTS);
	localparam int CW    = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;
	localparam int ENT_W = CHG_W + VOLT_W + RES_W;
	localparam int PV_W  = VOLT_W + CHG_W + 2;
	localparam int PR_W  = RES_W + CHG_W + 2;
	localparam int SUM_W = QUOT_W + 2;

	// Curve memory, one word per point: {charge, voltage, resistance}
	logic [ENT_W-1:0] curve_mem_q [MAX_POINTS];
	logic [ENT_W-1:0] rd_data_q;
	logic [IW-1:0]    wr_addr;
	logic [IW-1:0]    rd_addr;
	logic             wr_ok;

	logic [CHG_W-1:0]  rd_chg;
	logic [VOLT_W-1:0] rd_volt;
	logic [RES_W-1:0]  rd_res;

	// Effective point count
	logic [CW-1:0] n_full;
	logic [CW-1:0] n_eff;
	logic [IW-1:0] last_idx;

	// Search bounds
	logic [CHG_W-1:0] c_q;
	logic [IW-1:0]    lo_q;
	logic [IW-1:0]    hi_q;
	logic [IW-1:0]    lo_eff;
	logic [IW-1:0]    hi_eff;
	logic [IW-1:0]    mid_cur;
	logic [IW-1:0]    mid_eff;
	logic             srch_done;

	// Bracketing points
	logic [CHG_W-1:0]  a_chg_q;
	logic [VOLT_W-1:0] a_volt_q;
	logic [RES_W-1:0]  a_res_q;
	logic [CHG_W-1:0]  b_chg_q;
	logic [VOLT_W-1:0] b_volt_q;
	logic [RES_W-1:0]  b_res_q;

	// Multiply and divide
	logic signed [VOLT_W:0] dv;
	logic signed [RES_W:0]  dr;
	logic signed [CHG_W:0]  num_s;
	logic [CHG_W-1:0]       den;
	logic signed [PV_W-1:0] prod_v_q;
	logic signed [PR_W-1:0] prod_r_q;
	logic [PV_W-1:0]        abs_v;
	logic [PR_W-1:0]        abs_r;
	logic                   neg_v_q;
	logic                   neg_r_q;
	logic [MAG_W-1:0]       rem_v_q;
	logic [MAG_W-1:0]       rem_r_q;
	logic [MAG_W-1:0]       dsr_q;
	logic [QUOT_W-1:0]      quo_v_q;
	logic [QUOT_W-1:0]      quo_r_q;
	logic [QCNT_W-1:0]      cnt_q;
	logic                   ge_v;
	logic                   ge_r;

	// Final add and clamp
	logic signed [SUM_W-1:0] y1_v;
	logic signed [SUM_W-1:0] y1_r;
	logic signed [SUM_W-1:0] qs_v;
	logic signed [SUM_W-1:0] qs_r;
	logic signed [SUM_W-1:0] sum_v;
	logic signed [SUM_W-1:0] sum_r;
	logic [VOLT_W-1:0]       fin_v;
	logic [RES_W-1:0]        fin_r;

	logic              result_valid_q;
	logic [VOLT_W-1:0] voltage_q;
	logic [RES_W-1:0]  resistance_q;
	logic              out_of_model_q;

	assign {rd_chg, rd_volt, rd_res} = rd_data_q;

	// Point count limited to the table depth
	assign n_full   = CW'(point_count);
	assign n_eff    = (n_full < CW'(MAX_POINTS)) ? n_full : CW'(MAX_POINTS);
	assign last_idx = IW'(n_eff - CW'(1));

	// Writes past the table depth are dropped
	assign wr_ok   = cmd.wr && (32'(point_index) < 32'(MAX_POINTS));
	assign wr_addr = IW'(point_index);

	// Search step: fold in the compare of the word just read, then pick the next address
	assign mid_cur = IW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	always_comb begin
		lo_eff = lo_q;
		hi_eff = hi_q;
		if (cmd.srch_upd) begin
			if (rd_chg <= c_q) begin
				lo_eff = mid_cur;
			end else begin
				hi_eff = mid_cur;
			end
		end
	end
	assign mid_eff   = IW'(({1'b0, lo_eff} + {1'b0, hi_eff}) >> 1);
	assign srch_done = ((hi_eff - lo_eff) <= IW'(1));

	// Read address select
	always_comb begin
		unique case (cmd.rd_sel)
			SEL_ZERO:   rd_addr = '0;
			SEL_LAST:   rd_addr = last_idx;
			SEL_SEARCH: rd_addr = srch_done ? lo_eff : mid_eff;
			SEL_NEXT:   rd_addr = lo_q + IW'(1);
			default:    rd_addr = '0;
		endcase
	end

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			curve_mem_q[wr_addr] <= {point_charge, point_voltage, point_resistance};
		end
		if (cmd.rd_en) begin
			rd_data_q <= curve_mem_q[rd_addr];
		end
	end

	// Query and search bounds
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_q  <= query_charge;
			lo_q <= '0;
			hi_q <= last_idx;
		end else begin
			lo_q <= lo_eff;
			hi_q <= hi_eff;
		end
	end

	// Bracketing points
	always_ff @(posedge clk) begin
		if (cmd.latch_a) begin
			a_chg_q  <= rd_chg;
			a_volt_q <= rd_volt;
			a_res_q  <= rd_res;
		end
		if (cmd.latch_b) begin
			b_chg_q  <= rd_chg;
			b_volt_q <= rd_volt;
			b_res_q  <= rd_res;
		end
	end

	// Differences; numerator stays below the denominator
	assign dv    = $signed({1'b0, b_volt_q}) - $signed({1'b0, a_volt_q});
	assign dr    = $signed({1'b0, b_res_q}) - $signed({1'b0, a_res_q});
	assign num_s = $signed({1'b0, c_q - a_chg_q});
	assign den   = b_chg_q - a_chg_q;

	// Magnitudes of the products
	assign abs_v = prod_v_q[PV_W-1] ? PV_W'(-prod_v_q) : PV_W'(prod_v_q);
	assign abs_r = prod_r_q[PR_W-1] ? PR_W'(-prod_r_q) : PR_W'(prod_r_q);

	// Restoring divide, one quotient bit a cycle with a shifted divisor
	assign ge_v = (rem_v_q >= dsr_q);
	assign ge_r = (rem_r_q >= dsr_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_v_q <= dv * num_s;
			prod_r_q <= dr * num_s;
		end
		if (cmd.abs_init) begin
			neg_v_q <= prod_v_q[PV_W-1];
			neg_r_q <= prod_r_q[PR_W-1];
			rem_v_q <= MAG_W'(abs_v);
			rem_r_q <= MAG_W'(abs_r);
			dsr_q   <= MAG_W'(den) << (QUOT_W - 1);
			quo_v_q <= '0;
			quo_r_q <= '0;
			cnt_q   <= QCNT_W'(QUOT_W - 1);
		end else if (cmd.div_step) begin
			rem_v_q <= ge_v ? (rem_v_q - dsr_q) : rem_v_q;
			rem_r_q <= ge_r ? (rem_r_q - dsr_q) : rem_r_q;
			quo_v_q <= {quo_v_q[QUOT_W-2:0], ge_v};
			quo_r_q <= {quo_r_q[QUOT_W-2:0], ge_r};
			dsr_q   <= dsr_q >> 1;
			cnt_q   <= cnt_q - QCNT_W'(1);
		end
	end

	// Signed quotient onto the left value, then clamp to the field range
	assign y1_v  = SUM_W'(a_volt_q);
	assign y1_r  = SUM_W'(a_res_q);
	assign qs_v  = SUM_W'(quo_v_q);
	assign qs_r  = SUM_W'(quo_r_q);
	assign sum_v = neg_v_q ? (y1_v - qs_v) : (y1_v + qs_v);
	assign sum_r = neg_r_q ? (y1_r - qs_r) : (y1_r + qs_r);

	always_comb begin
		if (sum_v[SUM_W-1]) begin
			fin_v = '0;
		end else if (sum_v > SUM_W'(VOLT_MAX)) begin
			fin_v = VOLT_MAX;
		end else begin
			fin_v = sum_v[VOLT_W-1:0];
		end
		if (sum_r[SUM_W-1]) begin
			fin_r = '0;
		end else if (sum_r > SUM_W'(RES_MAX)) begin
			fin_r = RES_MAX;
		end else begin
			fin_r = sum_r[RES_W-1:0];
		end
	end

	// Result word, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (cmd.emit_sel)
				EMIT_EMPTY: begin
					voltage_q      <= '0;
					resistance_q   <= '0;
					out_of_model_q <= 1'b1;
				end
				EMIT_RD: begin
					voltage_q      <= rd_volt;
					resistance_q   <= rd_res;
					out_of_model_q <= 1'b1;
				end
				EMIT_LEFT: begin
					voltage_q      <= a_volt_q;
					resistance_q   <= a_res_q;
					out_of_model_q <= 1'b0;
				end
				EMIT_INTERP: begin
					voltage_q      <= fin_v;
					resistance_q   <= fin_r;
					out_of_model_q <= 1'b0;
				end
				default: begin
					voltage_q      <= '0;
					resistance_q   <= '0;
					out_of_model_q <= 1'b1;
				end
			endcase
		end
	end

	// Status
	assign sts.n_zero    = (point_count == '0);
	assign sts.c_le_rd   = (c_q <= rd_chg);
	assign sts.c_ge_rd   = (c_q >= rd_chg);
	assign sts.srch_done = srch_done;
	assign sts.den_zero  = (b_chg_q <= a_chg_q);
	assign sts.div_last  = (cnt_q == '0);

	assign result_valid = result_valid_q;
	assign voltage      = voltage_q;
	assign resistance   = resistance_q;
	assign out_of_model = out_of_model_q;

endmodule

// ===== rtl/core/battery_curve_interpolator.sv =====
// Top level of the battery curve interpolator: point count register, controller and datapath.
//
// Use: a request word is taken on a clock edge with start high and busy low. req_type
// selects a point write (point_index, point_charge, point_voltage, point_resistance) or
// a query (query_charge). A write finishes on the accepting edge and gives no result; a
// write at an index at or past MAX_POINTS is dropped. A query gives one result word
// (voltage, resistance, out_of_model), shown for exactly one cycle with result_valid.
// The receiver cannot stall; the word must be taken in that cycle.
// A query first checks for an empty table or a charge at/below the first point, then for a
// charge at/above the last point; each such case ends the query with out_of_model set.
// An interior charge goes on to a binary search over the table (at most ceil(log2(n - 1))
// steps, up to 6 for 64 points), reads of the two neighbor points, a multiply and the
// serial divider with its 20 quotient bits; repeated or descending neighbor charges end
// after the neighbor reads with the left point.
// The single read port of the curve memory sets the search pace, one point per cycle.
// busy stays high from the accept until the result cycle, so a new request can be taken
// on the edge that takes the result: a new query only after the last result, writes every cycle.
// point_count is written over the config channel (cfg_valid/cfg_ready, ready while idle
// and no request is offered). Reset clears point_count and the controller; the curve
// memory is not cleared and holds garbage until written.
module battery_curve_interpolator import bci_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              req_type,
	input  logic [PIDX_W-1:0] point_index,
	input  logic [CHG_W-1:0]  point_charge,
	input  logic [VOLT_W-1:0] point_voltage,
	input  logic [RES_W-1:0]  point_resistance,
	input  logic [CHG_W-1:0]  query_charge,
	output logic              result_valid,
	output logic [VOLT_W-1:0] voltage,
	output logic [RES_W-1:0]  resistance,
	output logic              out_of_model,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data
);

	bci_cmd_t         cmd;
	bci_sts_t         sts;
	logic [CNT_W-1:0] point_count_q;

	// Point count register; never changes on the edge that takes a request
	assign cfg_ready = !busy && !start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			point_count_q <= cfg_data;
		end
	end

	// Controller
	bci_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	// Datapath
	bci_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.point_count      (point_count_q),
		.point_index      (point_index),
		.point_charge     (point_charge),
		.point_voltage    (point_voltage),
		.point_resistance (point_resistance),
		.query_charge     (query_charge),
		.voltage          (voltage),
		.resistance       (resistance),
		.out_of_model     (out_of_model),
		.result_valid     (result_valid)
	);

endmodule
